// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the status LED breather RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check that a property holds at every clock edge outside reset
`define SLPB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("slpb assertion failed");
// Check that a condition never occurs outside reset
`define SLPB_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("slpb forbidden condition seen");
`else
`define SLPB_ASSERT(label, clk, rst, prop)
`define SLPB_NEVER(label, clk, rst, expr)
`endif

`endif

// ----- hw/rtl/slpb_pkg.sv -----
// Shared types, codes and helpers of the status LED breather.
`default_nettype none

package slpb_pkg;

  // Phase codes
  localparam logic [2:0] PHASE_IDLE      = 3'd0;
  localparam logic [2:0] PHASE_LISTENING = 3'd1;
  localparam logic [2:0] PHASE_DONE      = 3'd2;
  localparam logic [2:0] PHASE_FAILED    = 3'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_FULL_LEVEL     = 3'd0;
  localparam logic [2:0] CFG_FLOOR_LEVEL    = 3'd1;
  localparam logic [2:0] CFG_LISTEN_FLASH   = 3'd2;
  localparam logic [2:0] CFG_RESULT_FLASH   = 3'd3;
  localparam logic [2:0] CFG_BREATHE_PERIOD = 3'd4;

  // Register reset values
  localparam logic [7:0]  FULL_LEVEL_RST     = 8'd255;
  localparam logic [7:0]  FLOOR_LEVEL_RST    = 8'd16;
  localparam logic [15:0] LISTEN_FLASH_RST   = 16'd150;
  localparam logic [15:0] RESULT_FLASH_RST   = 16'd1000;
  localparam logic [15:0] BREATHE_PERIOD_RST = 16'd2000;

  localparam logic [7:0]  LEVEL_MAX  = 8'd255;
  localparam logic [15:0] PERIOD_MIN = 16'd2;

  // Serial divider width: dividend bits, one per step
  localparam int unsigned DIV_STEPS = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MOD,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Divide an 8-bit level by three through a reciprocal multiply
  function automatic logic [7:0] div3(input logic [7:0] lvl);
    logic [16:0] prod;
    prod = {9'd0, lvl} * 17'd171;
    return prod[16:9];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/slpb_div.sv -----
// Bit-serial restoring divider, 32-bit dividend by 16-bit divisor.
`default_nettype none
`include "assert_macros.svh"

module slpb_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [31:0]      quotient,
  output logic [15:0]      remainder
);

  logic [4:0]  cnt;
  logic [15:0] dsr;
  logic [16:0] trial;
  logic [16:0] diff;

  // Shift one dividend bit into the partial remainder and try the subtract
  assign trial = {remainder, quotient[31]};
  assign diff  = trial - {1'b0, dsr};

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(slpb_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Advance quotient and remainder one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      if (!diff[16]) begin
        remainder <= diff[15:0];
        quotient  <= {quotient[30:0], 1'b1};
      end else begin
        remainder <= trial[15:0];
        quotient  <= {quotient[30:0], 1'b0};
      end
    end
  end

  `SLPB_ASSERT(a_div_start_busy, clk, rst, start |=> busy)
  `SLPB_ASSERT(a_div_fell_done, clk, rst, $fell(busy) |-> done)
  `SLPB_NEVER(a_div_done_while_busy, clk, rst, done && busy)

endmodule

`default_nettype wire

// ----- hw/rtl/slpb_mul.sv -----
// Bit-serial shift-and-add multiplier, 8-bit by 16-bit.
`default_nettype none

module slpb_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [7:0]  mcand_a,
  input  wire logic [15:0] mcand_b,
  output logic             done,
  output logic [23:0]      product
);

  logic        busy;
  logic [2:0]  cnt;
  logic [7:0]  abits;
  logic [15:0] bval;

  // Sequence eight steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd7) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Take one multiplier bit a cycle, most significant first
  always_ff @(posedge clk) begin
    if (start) begin
      abits   <= mcand_a;
      bval    <= mcand_b;
      product <= '0;
    end else if (busy) begin
      abits   <= {abits[6:0], 1'b0};
      product <= {product[22:0], 1'b0} + (abits[7] ? {8'd0, bval} : 24'd0);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/status_led_phase_breather.sv -----
// Top level of the status LED breather: registers, sequencer and output stage.
`default_nettype none
`include "assert_macros.svh"

// Drives an RGB status LED from phase changes and periodic updates. A follow
// item (tuser 0) that changes the phase gives its result via EVAL and EMIT,
// once the output is free. An update item while breathing gives a result if
// its level changes, after two passes of the 32-step bit-serial divider
// (elapsed time modulo period, then the scaled level) and the 8-step serial
// multiplier. One item is worked on at a time; a finished result sits in the
// output register while the next item is taken.
// Configuration is taken on any cycle and should be written while idle.
module status_led_phase_breather (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // phase[2:0], now_ms[34:3], zero pad
  input  wire logic [0:0]  s_tuser,   // action[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  slpb_pkg::state_t state, state_next;

  logic [7:0]  full_level;
  logic [7:0]  floor_level;
  logic [15:0] listen_flash_ms;
  logic [15:0] result_flash_ms;
  logic [15:0] breathe_period_ms;

  logic [2:0]  cur_phase;
  logic [31:0] flash_deadline;
  logic [31:0] breathe_start;
  logic [7:0]  last_level;

  logic        in_action;
  logic [2:0]  in_phase;
  logic [31:0] in_now;
  logic [23:0] res;

  logic        div_start, div_busy, div_done;
  logic [31:0] div_dividend, div_quo;
  logic [15:0] div_divisor, div_rem;
  logic        mul_start, mul_done;
  logic [23:0] mul_prod;

  logic [15:0] period;
  logic [14:0] half;
  logic [15:0] rise;
  logic [7:0]  diff;
  logic [7:0]  level;
  logic [31:0] due_diff;
  logic        flash_on;
  logic        flash_wait;
  logic        out_free;
  logic        div_pass;

  // Derive the breathing terms
  assign period   = (breathe_period_ms < slpb_pkg::PERIOD_MIN) ? slpb_pkg::PERIOD_MIN
                                                               : breathe_period_ms;
  assign half     = period[15:1];
  assign rise     = (div_rem < {1'b0, half}) ? div_rem : period - div_rem;
  assign diff     = (full_level > floor_level) ? full_level - floor_level : 8'd0;
  assign level    = floor_level + div_quo[7:0];
  assign due_diff = in_now - flash_deadline;
  assign flash_on   = (flash_deadline != 32'd0);
  assign flash_wait = flash_on && due_diff[31];
  assign out_free   = !m_tvalid || m_tready;
  assign div_pass   = (state == slpb_pkg::ST_MOD) || (state == slpb_pkg::ST_DIV);

  // Share the divider between the modulo and the level scaling
  assign div_dividend = (state == slpb_pkg::ST_EVAL) ? in_now - breathe_start
                                                     : {8'd0, mul_prod};
  assign div_divisor  = (state == slpb_pkg::ST_EVAL) ? period : {1'b0, half};

  slpb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  slpb_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand_a (diff),
    .mcand_b (rise),
    .done    (mul_done),
    .product (mul_prod)
  );

  // Hold configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      full_level        <= slpb_pkg::FULL_LEVEL_RST;
      floor_level       <= slpb_pkg::FLOOR_LEVEL_RST;
      listen_flash_ms   <= slpb_pkg::LISTEN_FLASH_RST;
      result_flash_ms   <= slpb_pkg::RESULT_FLASH_RST;
      breathe_period_ms <= slpb_pkg::BREATHE_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        slpb_pkg::CFG_FULL_LEVEL:     full_level        <= cfg_data[7:0];
        slpb_pkg::CFG_FLOOR_LEVEL:    floor_level       <= cfg_data[7:0];
        slpb_pkg::CFG_LISTEN_FLASH:   listen_flash_ms   <= cfg_data;
        slpb_pkg::CFG_RESULT_FLASH:   result_flash_ms   <= cfg_data;
        slpb_pkg::CFG_BREATHE_PERIOD: breathe_period_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slpb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit launches
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    mul_start  = 1'b0;
    unique case (state)
      slpb_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = slpb_pkg::ST_EVAL;
      end
      slpb_pkg::ST_EVAL: begin
        if (!in_action) begin
          state_next = (in_phase == cur_phase) ? slpb_pkg::ST_IDLE : slpb_pkg::ST_EMIT;
        end else if (flash_wait) begin
          state_next = slpb_pkg::ST_IDLE;
        end else if (flash_on && cur_phase != slpb_pkg::PHASE_LISTENING) begin
          state_next = slpb_pkg::ST_EMIT;
        end else if (cur_phase != slpb_pkg::PHASE_LISTENING) begin
          state_next = slpb_pkg::ST_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = slpb_pkg::ST_MOD;
        end
      end
      slpb_pkg::ST_MOD: begin
        if (div_done) begin
          mul_start  = 1'b1;
          state_next = slpb_pkg::ST_MUL;
        end
      end
      slpb_pkg::ST_MUL: begin
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = slpb_pkg::ST_DIV;
        end
      end
      slpb_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = (level == last_level) ? slpb_pkg::ST_IDLE : slpb_pkg::ST_EMIT;
        end
      end
      slpb_pkg::ST_EMIT: begin
        if (out_free) state_next = slpb_pkg::ST_IDLE;
      end
      default: state_next = slpb_pkg::ST_IDLE;
    endcase
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_action <= s_tuser[0];
      in_phase  <= s_tdata[2:0];
      in_now    <= s_tdata[34:3];
    end
  end

  // Update LED state and stage the result
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_phase      <= slpb_pkg::PHASE_IDLE;
      flash_deadline <= '0;
      breathe_start  <= '0;
      last_level     <= slpb_pkg::LEVEL_MAX;
    end else begin
      if (state == slpb_pkg::ST_EVAL) begin
        if (!in_action) begin
          if (in_phase != cur_phase) begin
            cur_phase <= in_phase;
            if (in_phase == slpb_pkg::PHASE_LISTENING) begin
              flash_deadline <= in_now + {16'd0, listen_flash_ms};
              breathe_start  <= in_now;
              last_level     <= slpb_pkg::LEVEL_MAX;
              res            <= {full_level, full_level, full_level};
            end else if (cur_phase == slpb_pkg::PHASE_LISTENING &&
                         in_phase == slpb_pkg::PHASE_DONE) begin
              flash_deadline <= in_now + {16'd0, result_flash_ms};
              res            <= {8'd0, full_level, 8'd0};
            end else if (cur_phase == slpb_pkg::PHASE_LISTENING &&
                         in_phase == slpb_pkg::PHASE_FAILED) begin
              flash_deadline <= in_now + {16'd0, result_flash_ms};
              res            <= {8'd0, 8'd0, full_level};
            end else begin
              res <= '0;
            end
          end
        end else if (flash_on && !flash_wait) begin
          // Flash is due: drop it and blank the LED unless breathing follows
          flash_deadline <= '0;
          res            <= '0;
        end
      end
      if (state == slpb_pkg::ST_DIV && div_done && level != last_level) begin
        last_level <= level;
        res        <= {level, slpb_pkg::div3(level), 8'd0};
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == slpb_pkg::ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == slpb_pkg::ST_EMIT && out_free) begin
      m_tdata <= res;
    end
  end

  `SLPB_ASSERT(a_accept_to_eval, clk, rst, (s_tvalid && s_tready) |=> (state == slpb_pkg::ST_EVAL))
  `SLPB_ASSERT(a_load_from_emit, clk, rst, $rose(m_tvalid) |-> ($past(state) == slpb_pkg::ST_EMIT))
  `SLPB_ASSERT(a_div_done_state, clk, rst, div_done |-> div_pass)
  `SLPB_NEVER(a_div_start_idle, clk, rst, div_start && div_busy)

endmodule

`default_nettype wire
